/* hdl/ksrt_pkg.sv */
package ksrt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W        = 32;
  localparam int KEY_W       = 32;
  localparam int KIND_W      = 2;
  localparam int MODE_W      = 2;
  localparam int POS_W       = 6;
  localparam int OCC_W       = 7;
  localparam int IN_DATA_W   = 96;
  localparam int OUT_DATA_W  = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_UPSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_DESC  = 2'd0,
    MODE_ASC   = 2'd1,
    MODE_MIXED = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LEFT  = 2'd1,
    CELL_RIGHT = 2'd2,
    CELL_LOAD  = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [KEY_W-1:0] sec;
    logic [KEY_W-1:0] pri;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic ahead;
  } cell_stat_t;

  // True when entry a sorts strictly before entry b; ties break on ascending id.
  function automatic logic sorts_before(entry_t a, entry_t b, logic [MODE_W-1:0] mode);
    logic p_asc;
    logic s_asc;
    logic r;
    p_asc = (mode == MODE_ASC);
    s_asc = (mode == MODE_ASC) || (mode == MODE_MIXED);
    if (a.pri != b.pri) begin
      r = p_asc ? (a.pri < b.pri) : (a.pri > b.pri);
    end else if (a.sec != b.sec) begin
      r = s_asc ? (a.sec < b.sec) : (a.sec > b.sec);
    end else begin
      r = (a.id < b.id);
    end
    return r;
  endfunction

endpackage

/* hdl/keyed_sorted_rank_table.sv */
// Sorted table of up to 64 entries (id, primary key, secondary key) held in a row of
// cells. Each word on the input side is an upsert, delete or query and gives exactly
// one result word. For insert, delete and query the accept cycle compares the word
// against every cell at once, and the apply step then shifts the row and writes the
// result. An upsert of an id already held first shifts the moved entry toward the
// front; the entry then left at its old place is compared against the row a second
// time and moved toward the back. A result that is not taken holds the final step.
// The order mode must be written only while the block is idle; it is not enforced.
module keyed_sorted_rank_table
  import ksrt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [MODE_W-1:0]     cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // entry_id, primary_key, secondary_key
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [KIND_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // found, position, occupancy, table_full, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int N = TABLE_DEPTH;
  localparam logic [N-1:0] LSB = N'(1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_APPLY  = 4'b0010,
    ST_XCMP   = 4'b0100,
    ST_XAPPLY = 4'b1000
  } state_e;

  function automatic logic [N-1:0] lowest(logic [N-1:0] x);
    return x & (~x + LSB);
  endfunction

  function automatic logic [N-1:0] rev(logic [N-1:0] x);
    logic [N-1:0] r;
    for (int k = 0; k < N; k++) begin
      r[k] = x[N-1-k];
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] enc(logic [N-1:0] oh);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int k = 0; k < N; k++) begin
      if (oh[k]) begin
        r = r | IDX_W'(k);
      end
    end
    return r;
  endfunction

  state_e            state_q, state_d;
  logic [N-1:0]      v_q, v_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [MODE_W-1:0] mode_q;
  logic [N-1:0]      m_q;
  logic [N-1:0]      lt_q;
  entry_t            e_q;
  logic [KIND_W-1:0] op_q;
  entry_t            x_q, x_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic              moved_q, moved_d;
  logic              out_valid_q;
  logic [OUT_DATA_W-1:0] out_q, out_d;
  logic              out_we;

  entry_t            in_entry;
  entry_t            bcast;
  entry_t            cell_entry [N];
  cell_stat_t        cell_stat  [N];
  cell_op_e          cell_op    [N];
  logic [N-1:0]      hit_vec;
  logic [N-1:0]      ahead_vec;

  logic              accept;
  logic              out_free;
  logic              found;
  logic [N-1:0]      below, w, l1, rng, f, first, ge, above, rr;
  logic [N:0]        stop, s1;
  entry_t            xl;
  logic              res_found;
  logic [IDX_W-1:0]  res_pos;
  logic              res_full;

  assign in_entry.id  = s_axis_tdata[31:0];
  assign in_entry.pri = s_axis_tdata[63:32];
  assign in_entry.sec = s_axis_tdata[95:64];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    case (state_q)
      ST_IDLE:  bcast = in_entry;
      ST_APPLY: bcast = e_q;
      default:  bcast = x_q;
    endcase
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    entry_t left_n;
    entry_t right_n;
    if (k == 0) begin : g_first
      assign left_n = bcast;
    end else begin : g_mid_l
      assign left_n = cell_entry[k-1];
    end
    if (k == N - 1) begin : g_last
      assign right_n = cell_entry[k];
    end else begin : g_mid_r
      assign right_n = cell_entry[k+1];
    end
    ksrt_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[k]),
      .mode_i  (mode_q),
      .bcast_i (bcast),
      .left_i  (left_n),
      .right_i (right_n),
      .entry_o (cell_entry[k]),
      .stat_o  (cell_stat[k])
    );
    assign hit_vec[k]   = cell_stat[k].hit && v_q[k];
    assign ahead_vec[k] = cell_stat[k].ahead;
  end

  always_comb begin
    state_d   = state_q;
    v_d       = v_q;
    count_d   = count_q;
    x_d       = x_q;
    pos_d     = pos_q;
    moved_d   = moved_q;
    out_we    = 1'b0;
    res_found = 1'b0;
    res_pos   = '0;
    res_full  = 1'b0;
    for (int k = 0; k < N; k++) begin
      cell_op[k] = CELL_HOLD;
    end

    found = |m_q;
    below = m_q - LSB;
    above = ~(m_q | below);
    w     = ~lt_q & below;
    l1    = (w == '0) ? LSB : (rev(lowest(rev(w))) << 1);
    rng   = '0;
    f     = lt_q & v_q;
    first = (f == '0) ? (v_q + LSB) : lowest(f);
    ge    = '0;
    stop  = {1'b1, (lt_q | ~v_q) & above};
    s1    = stop & (~stop + (N + 1)'(1));
    rr    = s1[N:1];
    xl    = '0;
    for (int k = 0; k < N - 1; k++) begin
      if (m_q[k+1]) begin
        xl = xl | cell_entry[k];
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        res_found = found;
        if (op_q == KIND_UPSERT && found) begin
          // Move the entry toward the front while it sorts before its neighbor.
          rng     = ~(l1 - LSB) & (m_q | below);
          moved_d = (l1 != m_q);
          x_d     = (l1 != m_q) ? xl : e_q;
          pos_d   = enc(l1);
          for (int k = 0; k < N; k++) begin
            if (l1[k]) begin
              cell_op[k] = CELL_LOAD;
            end else if (rng[k]) begin
              cell_op[k] = CELL_LEFT;
            end
          end
          state_d = ST_XCMP;
        end else if (out_free) begin
          out_we  = 1'b1;
          state_d = ST_IDLE;
          if (op_q == KIND_UPSERT) begin
            if (v_q[N-1]) begin
              res_full = 1'b1;
            end else begin
              ge = ~(first - LSB);
              for (int k = 0; k < N; k++) begin
                if (first[k]) begin
                  cell_op[k] = CELL_LOAD;
                end else if (ge[k]) begin
                  cell_op[k] = CELL_LEFT;
                end
              end
              v_d     = {v_q[N-2:0], 1'b1};
              count_d = count_q + CNT_W'(1);
              res_pos = enc(first);
            end
          end else if (op_q == KIND_DELETE) begin
            if (found) begin
              ge = ~(m_q - LSB);
              for (int k = 0; k < N; k++) begin
                if (ge[k]) begin
                  cell_op[k] = CELL_RIGHT;
                end
              end
              v_d     = v_q >> 1;
              count_d = count_q - CNT_W'(1);
            end
          end else begin
            res_pos = enc(m_q);
          end
        end
      end
      ST_XCMP: begin
        state_d = ST_XAPPLY;
      end
      ST_XAPPLY: begin
        res_found = 1'b1;
        res_pos   = moved_q ? pos_q : enc(rr);
        if (out_free) begin
          // Move the entry left at the old place toward the back.
          rng = ~(m_q - LSB) & (rr | (rr - LSB));
          for (int k = 0; k < N; k++) begin
            if (rr[k]) begin
              cell_op[k] = CELL_LOAD;
            end else if (rng[k]) begin
              cell_op[k] = CELL_RIGHT;
            end
          end
          out_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_d = {1'b0, res_full, OCC_W'(count_d), POS_W'(res_pos), res_found};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      v_q         <= '0;
      count_q     <= '0;
      mode_q      <= MODE_DESC;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v_q     <= v_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (out_we) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_q  <= hit_vec;
      lt_q <= ahead_vec;
      e_q  <= in_entry;
      op_q <= s_axis_tuser;
    end else if (state_q == ST_XCMP) begin
      lt_q <= ahead_vec;
    end
    x_q     <= x_d;
    pos_q   <= pos_d;
    moved_q <= moved_d;
    if (out_we) begin
      out_q <= out_d;
    end
  end

endmodule

/* hdl/ksrt_cell.sv */
module ksrt_cell
  import ksrt_pkg::*;
(
  input  logic              clk_i,
  input  cell_op_e          op_i,
  input  logic [MODE_W-1:0] mode_i,
  input  entry_t            bcast_i,
  input  entry_t            left_i,
  input  entry_t            right_i,
  output entry_t            entry_o,
  output cell_stat_t        stat_o
);

  entry_t entry_q;
  entry_t entry_d;

  always_comb begin
    case (op_i)
      CELL_HOLD:  entry_d = entry_q;
      CELL_LEFT:  entry_d = left_i;
      CELL_RIGHT: entry_d = right_i;
      CELL_LOAD:  entry_d = bcast_i;
      default:    entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o      = entry_q;
  assign stat_o.hit   = (entry_q.id == bcast_i.id);
  assign stat_o.ahead = sorts_before(bcast_i, entry_q, mode_i);

endmodule
